@@ rtl/core/greedy_ensemble_selection_defines.svh @@
// ---------------------------------------------------------------------------
// greedy_ensemble_selection_defines
// Assertion helper macros for the greedy ensemble selection block.
// ---------------------------------------------------------------------------
`ifndef GREEDY_ENSEMBLE_SELECTION_DEFINES_SVH
`define GREEDY_ENSEMBLE_SELECTION_DEFINES_SVH
// implication checked every clock, idle during reset
`define GES_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define GES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ rtl/core/ges_pkg.sv @@
// ---------------------------------------------------------------------------
// ges_pkg
// Shared types and codes for greedy ensemble selection.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ges_pkg;
   localparam logic [1:0] CMD_LOAD_TARGET = 2'd0;
   localparam logic [1:0] CMD_LOAD_PRED   = 2'd1;
   localparam logic [1:0] CMD_RUN         = 2'd2;

   localparam logic [1:0] REG_METRIC = 2'd0;
   localparam logic [1:0] REG_ITER   = 2'd1;
   localparam logic [1:0] REG_ROWS   = 2'd2;
   localparam logic [1:0] REG_MODELS = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic clear_run;    // clear sum store and counts
      logic clear_acc;    // start scoring one model
      logic score;        // row beat, score phase
      logic add_best;     // row beat, update phase
      logic pick;         // commit winner count
      logic compare;      // compare accumulator against best
      logic pipe_flush;   // last row issued
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic pipe_busy;
   } status_type;
endpackage
`default_nettype wire

@@ rtl/core/ges_datapath.sv @@
// ---------------------------------------------------------------------------
// ges_datapath
// Sample stores, ensemble sum, error scoring pipeline, argmin and counts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ges_datapath #(
   parameter int MAX_ROWS     = 1024,
   parameter int MAX_MODELS   = 16,
   parameter int SAMPLE_WIDTH = 16,
   parameter int RW           = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   parameter int MW           = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire ges_pkg::ctrl_type   ctrl,
   output ges_pkg::status_type      status,
   input  wire                      metric,
   input  wire  [8:0]               round_num,
   input  wire  [RW-1:0]            row_addr,
   input  wire  [MW-1:0]            model_addr,
   input  wire                      wr_target,
   input  wire                      wr_pred,
   input  wire  [RW-1:0]            wr_row,
   input  wire  [MW-1:0]            wr_model,
   input  wire  [SAMPLE_WIDTH-1:0]  wr_data,
   input  wire  [MW-1:0]            rd_model,
   output logic [8:0]               rd_count
);
   localparam int SW   = SAMPLE_WIDTH + 10;   // sum of up to 256 samples
   localparam int EW   = SW + 2;              // error width
   localparam int MAGW = EW;

   logic signed [SAMPLE_WIDTH-1:0] target_mem [MAX_ROWS];
   logic signed [SAMPLE_WIDTH-1:0] pred_mem   [MAX_ROWS*MAX_MODELS];
   logic signed [SW-1:0]           sum_mem    [MAX_ROWS];
   logic [8:0]                     count_ff   [MAX_MODELS];

   logic signed [SAMPLE_WIDTH-1:0] tgt_q_ff, pred_q_ff;
   logic signed [SW-1:0]           sum_q_ff;
   logic                           s1_score_ff, s1_add_ff;
   logic [RW-1:0]                  s1_row_ff;
   logic signed [EW-1:0]           err_ff;
   logic                           s2_ff;
   logic [MAGW-1:0]                mag_ff;
   logic                           s3_ff, s3_mode_ff;
   logic [63:0]                    term_ff;
   logic                           s4_ff;
   logic [63:0]                    acc_ff, acc_in;
   logic [63:0]                    best_err_ff;
   logic [MW-1:0]                  best_ff;
   logic                           have_best_ff;
   logic [RW+MW-1:0]               pred_rd_addr;
   logic [RW+MW-1:0]               pred_wr_addr;
   logic signed [EW-1:0]           prod_rt, err_in;
   logic [MAGW-1:0]                mag_in;
   logic [2*MAGW-1:0]              sq;
   logic [64:0]                    sum65;

   // column-major layout: model * MAX_ROWS + row
   assign pred_rd_addr = (RW+MW)'(32'(ctrl.add_best ? best_ff : model_addr) * MAX_ROWS
                                  + 32'(row_addr));
   assign pred_wr_addr = (RW+MW)'(32'(wr_model) * MAX_ROWS + 32'(wr_row));

   always_ff @(posedge clock) begin
      if (wr_target) target_mem[wr_row] <= wr_data;
      if (wr_pred)   pred_mem[pred_wr_addr] <= wr_data;
      tgt_q_ff  <= target_mem[row_addr];
      pred_q_ff <= pred_mem[pred_rd_addr];
      sum_q_ff  <= sum_mem[row_addr];
      if (s1_add_ff) sum_mem[s1_row_ff] <= sum_q_ff + SW'(pred_q_ff);
      if (ctrl.clear_run) sum_mem[row_addr] <= '0;
   end

   // stage 2: error; stage 3: magnitude; stage 4: square or pass
   assign prod_rt = EW'(tgt_q_ff) * $signed({1'b0, round_num});
   assign err_in  = prod_rt - (EW'(sum_q_ff) + EW'(pred_q_ff));
   assign mag_in  = err_ff[EW-1] ? MAGW'(-err_ff) : MAGW'(err_ff);
   assign sq      = mag_ff * mag_ff;
   assign sum65   = {1'b0, acc_ff} + {1'b0, term_ff};

   always_ff @(posedge clock) begin
      s1_row_ff <= row_addr;
      err_ff    <= err_in;
      mag_ff    <= mag_in;
      s3_mode_ff <= metric;
      term_ff   <= s3_mode_ff ? 64'(mag_ff) : 64'(sq);
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear_acc) acc_in = '0;
      else if (s4_ff) acc_in = sum65[64] ? '1 : sum65[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_score_ff <= 1'b0;
         s1_add_ff   <= 1'b0;
         s2_ff <= 1'b0;
         s3_ff <= 1'b0;
         s4_ff <= 1'b0;
         have_best_ff <= 1'b0;
         best_ff <= '0;
         best_err_ff <= '0;
         acc_ff <= '0;
         for (int k = 0; k < MAX_MODELS; k++) count_ff[k] <= '0;
      end else begin
         s1_score_ff <= ctrl.score;
         s1_add_ff   <= ctrl.add_best;
         s2_ff <= s1_score_ff;
         s3_ff <= s2_ff;
         s4_ff <= s3_ff;
         acc_ff <= acc_in;
         if (ctrl.clear_run)
            for (int k = 0; k < MAX_MODELS; k++) count_ff[k] <= '0;
         if (ctrl.compare) begin
            if (!have_best_ff || acc_ff < best_err_ff) begin
               best_err_ff <= acc_ff;
               best_ff <= model_addr;
            end
            have_best_ff <= 1'b1;
         end
         if (ctrl.pick) begin
            count_ff[best_ff] <= count_ff[best_ff] + 9'd1;
            have_best_ff <= 1'b0;
         end
      end
   end

   assign status.pipe_busy = s1_score_ff | s2_ff | s3_ff | s4_ff | s1_add_ff
                             | ctrl.pipe_flush;
   assign rd_count = count_ff[rd_model];
endmodule
`default_nettype wire

@@ rtl/core/ges_controller.sv @@
// ---------------------------------------------------------------------------
// ges_controller
// Sequencer for clear, score, compare, update and report phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "greedy_ensemble_selection_defines.svh"
module ges_controller #(
   parameter int MAX_ROWS   = 1024,
   parameter int MAX_MODELS = 16,
   parameter int RW         = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   parameter int MW         = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  wire  [7:0]             iter_limit,
   input  wire  [10:0]            rows_cfg,
   input  wire  [4:0]             models_cfg,
   output ges_pkg::ctrl_type      ctrl,
   input  wire ges_pkg::status_type status,
   output logic [8:0]             round_num,
   output logic [RW-1:0]          row_addr,
   output logic [MW-1:0]          model_addr,
   output logic                   out_valid,
   input  wire                    out_ready,
   output logic [MW-1:0]          out_model,
   output logic                   out_last,
   output logic [8:0]             total
);
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CLEAR  = 3'd1;
   localparam logic [2:0] ST_SCORE  = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_UPDATE = 3'd4;
   localparam logic [2:0] ST_UDRAIN = 3'd5;
   localparam logic [2:0] ST_EMIT   = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [RW:0]   row_ff, row_in;
   logic [MW:0]   mdl_ff, mdl_in;
   logic [8:0]    round_ff, round_in;
   logic [RW:0]   nrows;
   logic [MW:0]   nmodels;
   logic          row_end, mdl_end;

   always_comb begin
      if (rows_cfg == 11'd0) nrows = (RW+1)'(1);
      else if ({21'd0, rows_cfg} > 32'(MAX_ROWS)) nrows = (RW+1)'(MAX_ROWS);
      else nrows = (RW+1)'(rows_cfg);
      if (models_cfg == 5'd0) nmodels = (MW+1)'(1);
      else if ({27'd0, models_cfg} > 32'(MAX_MODELS)) nmodels = (MW+1)'(MAX_MODELS);
      else nmodels = (MW+1)'(models_cfg);
   end

   assign row_end = (row_ff + 1'b1) == nrows;
   assign mdl_end = (mdl_ff + 1'b1) == nmodels;

   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      mdl_in = mdl_ff;
      round_in = round_ff;
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CLEAR;
               row_in = '0;
               ctrl.clear_run = 1'b1;
            end
         end
         ST_CLEAR: begin
            // sweeps the sum store one row a cycle
            ctrl.clear_run = 1'b1;
            row_in = row_ff + 1'b1;
            if (row_ff == (RW+1)'(MAX_ROWS - 1)) begin
               state_in = ST_SCORE;
               row_in = '0;
               mdl_in = '0;
               round_in = 9'd1;
               ctrl.clear_acc = 1'b1;
            end
         end
         ST_SCORE: begin
            ctrl.score = 1'b1;
            row_in = row_ff + 1'b1;
            if (row_end) begin
               ctrl.pipe_flush = 1'b1;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               ctrl.compare = 1'b1;
               row_in = '0;
               if (mdl_end) begin
                  state_in = ST_UPDATE;
               end else begin
                  mdl_in = mdl_ff + 1'b1;
                  ctrl.clear_acc = 1'b1;
                  state_in = ST_SCORE;
               end
            end
         end
         ST_UPDATE: begin
            ctrl.add_best = 1'b1;
            row_in = row_ff + 1'b1;
            if (row_end) begin
               ctrl.pipe_flush = 1'b1;
               state_in = ST_UDRAIN;
            end
         end
         ST_UDRAIN: begin
            if (!status.pipe_busy) begin
               ctrl.pick = 1'b1;
               row_in = '0;
               mdl_in = '0;
               if (round_ff == {1'b0, iter_limit} + 9'd1) begin
                  state_in = ST_EMIT;
               end else begin
                  round_in = round_ff + 9'd1;
                  ctrl.clear_acc = 1'b1;
                  state_in = ST_SCORE;
               end
            end
         end
         ST_EMIT: begin
            if (out_ready) begin
               if (mdl_end) state_in = ST_IDLE;
               else mdl_in = mdl_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff <= '0;
         mdl_ff <= '0;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         mdl_ff <= mdl_in;
         round_ff <= round_in;
      end
   end

   assign busy       = state_ff != ST_IDLE;
   assign round_num  = round_ff;
   assign row_addr   = row_ff[RW-1:0];
   assign model_addr = mdl_ff[MW-1:0];
   assign out_valid  = state_ff == ST_EMIT;
   assign out_model  = mdl_ff[MW-1:0];
   assign out_last   = mdl_end;
   assign total      = round_ff;

   `GES_ASSERT_NEXT(a_emit_hold, clock, reset, out_valid && !out_ready,
      out_valid && $stable(out_model), "result dropped while stalled")
   `GES_ASSERT_IMP(a_score_rows, clock, reset, ctrl.score, row_ff < nrows,
      "row counter ran past rows in use")
   `GES_ASSERT_IMP(a_round_range, clock, reset, state_ff == ST_SCORE,
      round_ff != 9'd0 && round_ff <= {1'b0, iter_limit} + 9'd1,
      "round number out of range")
endmodule
`default_nettype wire

@@ rtl/core/greedy_ensemble_selection.sv @@
// ---------------------------------------------------------------------------
// greedy_ensemble_selection
// Greedy ensemble selection with replacement over stored model predictions.
// ---------------------------------------------------------------------------
// Usage:
//  req_ channel: each transaction carries a command. Load target and load
//  prediction commands write one sample each, so loads stream at one per
//  cycle while no run or result is pending. A run command clears the ensemble
//  sum (a pass over all MAX_ROWS rows) and then runs iteration_limit+1 rounds.
//  Each round scores every model over rows_in_use rows at one row per cycle
//  through a four-stage error pipeline (plus a drain of the pipeline per
//  model), then adds the winner's column into the sum.
//  rsp_ channel: a run yields one transaction per model in use with its pick
//  count and the round total; tlast marks the final model. req_tready stays
//  low during a run and while results wait; a stalled receiver simply holds
//  the result stage. csr_ writes are taken at any time but should be made
//  while idle. Reset (synchronous) restores the register defaults and the
//  controller; sample stores stay undefined until loaded.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "greedy_ensemble_selection_defines.svh"
module greedy_ensemble_selection #(
   parameter int MAX_ROWS     = 1024,
   parameter int MAX_MODELS   = 16,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // tdata: row_index[9:0], model_index[13:10], sample_value[29:14], zero pad
   input  wire  [31:0] req_tdata,
   // tuser: command[1:0]
   input  wire  [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // tdata: model_number[3:0], pick_count[12:4], total_picks[21:13], zero pad
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [31:0] csr_data
);
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int MW = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1;

   logic        metric_ff;
   logic [7:0]  iter_ff;
   logic [10:0] rows_ff;
   logic [4:0]  models_ff;

   logic [1:0]  cmd;
   logic [9:0]  in_row;
   logic [3:0]  in_model;
   logic        accept, busy, start, row_ok, mdl_ok;
   ges_pkg::ctrl_type   ctrl;
   ges_pkg::status_type status;
   logic [8:0]    round_num, rd_count, total;
   logic [RW-1:0] row_addr;
   logic [MW-1:0] model_addr, out_model;

   assign cmd      = req_tuser;
   assign in_row   = req_tdata[9:0];
   assign in_model = req_tdata[13:10];
   assign req_tready = !busy;
   assign accept   = req_tvalid && req_tready;
   assign start    = accept && cmd == ges_pkg::CMD_RUN;
   assign row_ok   = 32'(in_row) < 32'(MAX_ROWS);
   assign mdl_ok   = 32'(in_model) < 32'(MAX_MODELS);

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= 1'b0;
         iter_ff   <= 8'd100;
         rows_ff   <= 11'd1024;
         models_ff <= 5'd16;
      end else if (csr_valid) begin
         case (csr_index)
            ges_pkg::REG_METRIC: metric_ff <= csr_data[0];
            ges_pkg::REG_ITER:   iter_ff   <= csr_data[7:0];
            ges_pkg::REG_ROWS:   rows_ff   <= csr_data[10:0];
            ges_pkg::REG_MODELS: models_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   ges_controller #(.MAX_ROWS(MAX_ROWS), .MAX_MODELS(MAX_MODELS)) u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .iter_limit(iter_ff), .rows_cfg(rows_ff), .models_cfg(models_ff),
      .ctrl(ctrl), .status(status), .round_num(round_num),
      .row_addr(row_addr), .model_addr(model_addr),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_model(out_model),
      .out_last(rsp_tlast), .total(total)
   );

   ges_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_MODELS(MAX_MODELS),
                  .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .status(status),
      .metric(metric_ff), .round_num(round_num),
      .row_addr(row_addr), .model_addr(model_addr),
      .wr_target(accept && cmd == ges_pkg::CMD_LOAD_TARGET && row_ok),
      .wr_pred(accept && cmd == ges_pkg::CMD_LOAD_PRED && row_ok && mdl_ok),
      .wr_row(RW'(in_row)), .wr_model(MW'(in_model)),
      .wr_data(SAMPLE_WIDTH'(req_tdata[29:14])),
      .rd_model(out_model), .rd_count(rd_count)
   );

   assign rsp_tdata = {2'b00, total, rd_count, 4'(out_model)};

   `GES_ASSERT_IMP(a_no_accept_busy, clock, reset, busy, !req_tready,
      "request taken during run")
   `GES_ASSERT_IMP(a_total_nonzero, clock, reset, rsp_tvalid, total != 9'd0,
      "result with zero rounds")
endmodule
`default_nettype wire

@@ tb/tb_greedy_ensemble_selection.sv @@
// ----------------------------------------------------------------------------
// tb_greedy_ensemble_selection
// Self-checking bench: loads target and prediction columns, issues runs under
// several register settings, predicts the pick counts and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_greedy_ensemble_selection;
   localparam int ROWS_MAX   = 1024;
   localparam int MODELS_MAX = 16;
   localparam longint CYCLE_LIMIT = 4000000;
   // command value with no meaning, must be ignored
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [23:0] rsp_tdata;
   wire         rsp_tlast;
   logic        csr_valid = 1'b0;
   wire         csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   greedy_ensemble_selection u_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   typedef struct packed {
      logic [1:0]  cmd;
      logic [9:0]  row;
      logic [3:0]  mdl;
      logic [15:0] value;
   } load_item_type;

   typedef struct packed {
      logic [3:0] mdl;
      logic [8:0] count;
      logic [8:0] total;
      logic       last;
   } pick_result_type;

   // Shadow of the block state, used at enqueue time (driver keeps order).
   logic signed [15:0] target_col [ROWS_MAX];
   logic signed [15:0] pred_col   [MODELS_MAX][ROWS_MAX];
   logic [0:0]  mode_q;
   logic [7:0]  iter_q;
   logic [10:0] rows_q;
   logic [4:0]  models_q;

   load_item_type   pending_items[$];
   pick_result_type expected_picks[$];

   int  send_idle_pct = 9;
   int  recv_idle_pct = 50;
   bit  hold_off = 1'b0;
   int  errors = 0;
   longint cycles = 0;

   // Compute the greedy selection for the current shadow state.
   function automatic void predict_picks();
      int rows_n, models_n, rounds, best;
      logic signed [63:0] ens [ROWS_MAX];
      logic [63:0] score [MODELS_MAX];
      logic [8:0]  counts [MODELS_MAX];
      logic signed [63:0] e;
      logic [63:0] mag, term, acc;
      pick_result_type res;
      rows_n = (rows_q < 1) ? 1 : (rows_q > ROWS_MAX) ? ROWS_MAX : rows_q;
      models_n = (models_q < 1) ? 1 : (models_q > MODELS_MAX) ? MODELS_MAX : models_q;
      rounds = iter_q + 1;
      for (int i = 0; i < ROWS_MAX; i++) ens[i] = 0;
      for (int j = 0; j < MODELS_MAX; j++) counts[j] = 0;
      for (int r = 1; r <= rounds; r++) begin
         for (int j = 0; j < models_n; j++) begin
            acc = 0;
            for (int i = 0; i < rows_n; i++) begin
               e = 64'(r) * 64'(target_col[i]) - (ens[i] + 64'(pred_col[j][i]));
               mag = e[63] ? -e : e;
               if (mode_q) term = mag;
               else if (mag > 64'hFFFF_FFFF) term = '1;
               else term = mag * mag;
               acc = (acc + term < acc) ? '1 : acc + term;
            end
            score[j] = acc;
         end
         best = 0;
         for (int j = 1; j < models_n; j++)
            if (score[j] < score[best]) best = j;
         for (int i = 0; i < rows_n; i++) ens[i] += 64'(pred_col[best][i]);
         counts[best]++;
      end
      for (int j = 0; j < models_n; j++) begin
         res.mdl = j[3:0];
         res.count = counts[j];
         res.total = rounds[8:0];
         res.last = (j == models_n - 1);
         expected_picks.push_back(res);
      end
   endfunction

   // Queue an item and update the shadow as the block will.
   task automatic queue_item(input logic [1:0] cmd, input int row, input int mdl,
                             input logic [15:0] value);
      load_item_type it;
      it.cmd = cmd; it.row = row[9:0]; it.mdl = mdl[3:0]; it.value = value;
      pending_items.push_back(it);
      if (cmd == ges_pkg::CMD_LOAD_TARGET) target_col[row] = value;
      else if (cmd == ges_pkg::CMD_LOAD_PRED) pred_col[mdl][row] = value;
      else if (cmd == ges_pkg::CMD_RUN) predict_picks();
   endtask

   // Wait until everything queued has gone through and been checked.
   task automatic drain();
      while (pending_items.size() != 0 || expected_picks.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ges_pkg::REG_METRIC: mode_q   = value[0];
         ges_pkg::REG_ITER:   iter_q   = value[7:0];
         ges_pkg::REG_ROWS:   rows_q   = value[10:0];
         ges_pkg::REG_MODELS: models_q = value[4:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(input int mode, input int iter, input int rows, input int models);
      write_reg(ges_pkg::REG_METRIC, mode);
      write_reg(ges_pkg::REG_ITER, iter);
      write_reg(ges_pkg::REG_ROWS, rows);
      write_reg(ges_pkg::REG_MODELS, models);
   endtask

   // Fill every row/model used by a run so no unwritten entry is read.
   task automatic load_columns(input int rows, input int models, input bit wild);
      for (int i = 0; i < rows; i++)
         queue_item(ges_pkg::CMD_LOAD_TARGET, i, $urandom_range(15, 0),
                    wild ? 16'($urandom) : 16'($urandom_range(1024, 0) - 512));
      for (int j = 0; j < models; j++)
         for (int i = 0; i < rows; i++)
            queue_item(ges_pkg::CMD_LOAD_PRED, i, j,
                       wild ? 16'($urandom) : 16'($urandom_range(1024, 0) - 512));
   endtask

   // Driver: offers the queued items.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               {req_tuser, req_tdata} <= {pending_items[0].cmd, 2'b00,
                  pending_items[0].value, pending_items[0].mdl, pending_items[0].row};
               void'(pending_items.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end else if (!req_tvalid && pending_items.size() != 0
                      && $urandom_range(99, 0) >= send_idle_pct) begin
            {req_tuser, req_tdata} <= {pending_items[0].cmd, 2'b00,
               pending_items[0].value, pending_items[0].mdl, pending_items[0].row};
            req_tvalid <= 1'b1;
            void'(pending_items.pop_front());
         end
      end
   end

   // Monitor: ready pattern plus result check.
   always @(posedge clock) begin
      pick_result_type got, want;
      if (!reset) begin
         rsp_tready <= !hold_off && ($urandom_range(99, 0) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            got.mdl = rsp_tdata[3:0];
            got.count = rsp_tdata[12:4];
            got.total = rsp_tdata[21:13];
            got.last = rsp_tlast;
            if (expected_picks.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
               errors++;
            end else begin
               want = expected_picks.pop_front();
               if (got != want) begin
                  $display("%0t: mismatch expected mdl %0d cnt %0d tot %0d last %0b,",
                           $time, want.mdl, want.count, want.total, want.last);
                  $display("   actual mdl %0d cnt %0d tot %0d last %0b",
                           got.mdl, got.count, got.total, got.last);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Long receiver stall, counted in its own process; starts on the first
   // result while the next run is already being offered.
   initial begin
      int stall;
      wait (!reset);
      do @(posedge clock); while (!rsp_tvalid);
      hold_off = 1'b1;
      stall = 0;
      while (stall < 600) begin
         @(posedge clock);
         stall++;
      end
      hold_off = 1'b0;
   end

   initial begin
      for (int i = 0; i < ROWS_MAX; i++) target_col[i] = 0;
      for (int j = 0; j < MODELS_MAX; j++)
         for (int i = 0; i < ROWS_MAX; i++) pred_col[j][i] = 0;
      mode_q = 0; iter_q = 100; rows_q = 1024; models_q = 16;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, both metrics, ignored command, out-of-use loads.
      set_regs(0, 3, 2, 2);
      queue_item(ges_pkg::CMD_LOAD_TARGET, 0, 15, 16'h7FFF);
      queue_item(ges_pkg::CMD_LOAD_TARGET, 1, 0, 16'h8000);
      queue_item(ges_pkg::CMD_LOAD_PRED, 0, 0, 16'h8000);
      queue_item(ges_pkg::CMD_LOAD_PRED, 1, 0, 16'h7FFF);
      queue_item(ges_pkg::CMD_LOAD_PRED, 0, 1, 16'h0000);
      queue_item(ges_pkg::CMD_LOAD_PRED, 1, 1, 16'hFFFF);
      queue_item(ges_pkg::CMD_LOAD_PRED, 1023, 15, 16'h5A5A);
      queue_item(ges_pkg::CMD_LOAD_TARGET, 1023, 0, 16'hA5A5);
      queue_item(CMD_RESERVED, 1023, 15, 16'hFFFF);
      queue_item(ges_pkg::CMD_RUN, 1023, 15, 16'hFFFF);
      // Ties: identical columns go to model 0.
      queue_item(ges_pkg::CMD_LOAD_PRED, 0, 1, 16'h8000);
      queue_item(ges_pkg::CMD_LOAD_PRED, 1, 1, 16'h7FFF);
      queue_item(ges_pkg::CMD_RUN, 0, 0, 0);
      drain();
      set_regs(1, 0, 2, 2);
      queue_item(ges_pkg::CMD_RUN, 0, 0, 0);
      drain();
      set_regs(0, 255, 1, 1);
      queue_item(ges_pkg::CMD_RUN, 0, 0, 0);
      drain();

      // Random phases under three idle patterns; the last one uses all 16 models.
      for (int ph = 0; ph < 9; ph++) begin
         int rows, models;
         if (ph == 3) begin send_idle_pct = 50; recv_idle_pct = 9; end
         if (ph == 6) begin send_idle_pct = 0;  recv_idle_pct = 0; end
         rows = $urandom_range(3, 1);
         models = (ph == 8) ? 16 : $urandom_range(16, 1);
         if (ph == 4) rows = 24;
         set_regs(ph % 2, (ph == 4) ? 0 : $urandom_range(20, 0),
                  rows, (ph == 4) ? 2 : models);
         if (ph == 4) load_columns(24, 2, ph[0]);
         else load_columns(rows, models, ph[0]);
         for (int k = 0; k < 3; k++)
            queue_item(ges_pkg::CMD_RUN, $urandom, $urandom, $urandom);
         drain();
      end
      set_regs(0, 255, 6, 16);
      load_columns(6, 16, 1'b1);
      queue_item(ges_pkg::CMD_RUN, 0, 0, 0);
      drain();

      if (expected_picks.size() != 0) errors++;
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
